@@ hw/rtl/mpc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package mpc_pkg;

  localparam int MOTORS  = 4;
  localparam int INTEG_W = 48;
  localparam int POS_W   = 32;
  localparam int GAIN_W  = 16;
  localparam int FRAC_W  = 16;
  localparam int ORDER_W = 16;
  localparam int CFG_W   = MOTORS * GAIN_W;
  localparam int ERR_W   = POS_W + 1;
  localparam int PROD_W  = ERR_W + GAIN_W + 1;
  localparam int INC_W   = PROD_W - FRAC_W;
  localparam int SUM_W   = INTEG_W + GAIN_W + 2;

  localparam logic [1:0] CFG_KP    = 2'd0;
  localparam logic [1:0] CFG_KI    = 2'd1;
  localparam logic [1:0] CFG_SCALE = 2'd2;

  localparam logic [GAIN_W-1:0] SCALE_RESET = '1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_INT,
    S_KI,
    S_OUT
  } state_e;

  typedef struct packed {
    logic start;
    logic mul;
    logic integ;
    logic ki;
  } lane_ctrl_t;

endpackage
`default_nettype wire

@@ hw/rtl/mpc_in_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface mpc_in_if;
  logic                                valid;
  logic                                ready;
  logic [mpc_pkg::ORDER_W-1:0]         order_id;
  logic [mpc_pkg::MOTORS-1:0]          inhibit_mask;
  logic signed [mpc_pkg::POS_W-1:0]    target_0;
  logic signed [mpc_pkg::POS_W-1:0]    target_1;
  logic signed [mpc_pkg::POS_W-1:0]    target_2;
  logic signed [mpc_pkg::POS_W-1:0]    target_3;
  logic signed [mpc_pkg::POS_W-1:0]    position_0;
  logic signed [mpc_pkg::POS_W-1:0]    position_1;
  logic signed [mpc_pkg::POS_W-1:0]    position_2;
  logic signed [mpc_pkg::POS_W-1:0]    position_3;

  modport source (
    output valid, order_id, inhibit_mask, target_0, target_1, target_2, target_3,
    output position_0, position_1, position_2, position_3,
    input  ready
  );

  modport sink (
    input  valid, order_id, inhibit_mask, target_0, target_1, target_2, target_3,
    input  position_0, position_1, position_2, position_3,
    output ready
  );
endinterface
`default_nettype wire

@@ hw/rtl/mpc_out_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface mpc_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [mpc_pkg::POS_W-1:0] speed_0;
  logic signed [mpc_pkg::POS_W-1:0] speed_1;
  logic signed [mpc_pkg::POS_W-1:0] speed_2;
  logic signed [mpc_pkg::POS_W-1:0] speed_3;

  modport source (
    output valid, speed_0, speed_1, speed_2, speed_3,
    input  ready
  );

  modport sink (
    input  valid, speed_0, speed_1, speed_2, speed_3,
    output ready
  );
endinterface
`default_nettype wire

@@ hw/rtl/mpc_lane.sv @@
`timescale 1ns / 1ps
`default_nettype none
module mpc_lane (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire mpc_pkg::lane_ctrl_t                 ctrl_i,
  input  wire logic                                clr_i,
  input  wire logic signed [mpc_pkg::POS_W-1:0]    target_i,
  input  wire logic signed [mpc_pkg::POS_W-1:0]    position_i,
  input  wire logic        [mpc_pkg::GAIN_W-1:0]   kp_i,
  input  wire logic        [mpc_pkg::GAIN_W-1:0]   ki_i,
  input  wire logic        [mpc_pkg::GAIN_W-1:0]   scale_i,
  output logic signed      [mpc_pkg::POS_W-1:0]    speed_o
);

  localparam int IW   = mpc_pkg::INTEG_W;
  localparam int LO_W = IW / 2;
  localparam int HI_W = IW - LO_W;
  localparam int KL_W = mpc_pkg::GAIN_W + LO_W + 2;
  localparam int KH_W = mpc_pkg::GAIN_W + HI_W + 1;
  localparam int SW   = mpc_pkg::SUM_W;
  localparam int PW   = mpc_pkg::POS_W;

  localparam logic signed [IW-1:0] I_MAX = {1'b0, {(IW-1){1'b1}}};
  localparam logic signed [IW-1:0] I_MIN = {1'b1, {(IW-1){1'b0}}};
  localparam logic signed [PW-1:0] S_MAX = {1'b0, {(PW-1){1'b1}}};
  localparam logic signed [PW-1:0] S_MIN = {1'b1, {(PW-1){1'b0}}};

  logic signed [mpc_pkg::ERR_W-1:0]  err_d, err_q;
  logic signed [mpc_pkg::PROD_W-1:0] ps_d, ps_q;
  logic signed [mpc_pkg::PROD_W-1:0] pp_d, pp_q;
  logic signed [mpc_pkg::INC_W-1:0]  inc;
  logic signed [IW:0]                isum;
  logic signed [IW-1:0]              integ_d, integ_q;
  logic signed [KL_W-1:0]            kl_d, kl_q;
  logic signed [KH_W-1:0]            kh_d, kh_q;
  logic signed [SW-1:0]              total;
  logic        [SW-PW:0]             upper;

  assign err_d = {target_i[PW-1], target_i} - {position_i[PW-1], position_i};
  assign ps_d  = err_q * $signed({1'b0, scale_i});
  assign pp_d  = err_q * $signed({1'b0, kp_i});

  // floor shift of the scaled error
  assign inc  = ps_q[mpc_pkg::PROD_W-1:mpc_pkg::FRAC_W];
  assign isum = (IW+1)'(integ_q) + (IW+1)'(inc);

  always_comb begin
    if (isum[IW] != isum[IW-1]) begin
      integ_d = isum[IW] ? I_MIN : I_MAX;
    end else begin
      integ_d = isum[IW-1:0];
    end
  end

  // integrator times ki in two halves
  assign kl_d = $signed({1'b0, ki_i}) * $signed({1'b0, integ_q[LO_W-1:0]});
  assign kh_d = $signed({1'b0, ki_i}) * $signed(integ_q[IW-1:LO_W]);

  assign total = SW'(pp_q) + (SW'(kh_q) <<< LO_W) + SW'(kl_q);
  assign upper = total[SW-1:PW-1];

  always_comb begin
    if ((&upper) || !(|upper)) begin
      speed_o = total[PW-1:0];
    end else begin
      speed_o = total[SW-1] ? S_MIN : S_MAX;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '0;
    end else if (ctrl_i.start && clr_i) begin
      integ_q <= '0;
    end else if (ctrl_i.integ) begin
      integ_q <= integ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      err_q <= err_d;
    end
    if (ctrl_i.mul) begin
      ps_q <= ps_d;
      pp_q <= pp_d;
    end
    if (ctrl_i.ki) begin
      kl_q <= kl_d;
      kh_q <= kh_d;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/multi_axis_pi_position_controller_top.sv @@
// four-axis pi position controller
// in_if carries one control tick per item: order id, inhibit mask and a target
// and measured position per motor, signed q16.16. out_if returns one item per
// input item with the four saturated speed orders.
// configuration: cfg_we_i writes cfg_data_i into register cfg_index_i
// (0 kp gains, 1 ki gains, 2 sample scale); other indexes are ignored.
// each motor has its own lane; a lane runs error, multiply, integrate and ki
// product steps, then the merge stage registers all four speeds.
// a new item is accepted only after the last one has run the four-step lane
// sequence and the output load.
// in_if.ready is high whenever the lanes are idle, also while a result waits
// in the output register. if the receiver stalls, the next item holds in the
// last lane step until the output register frees up.
// reset clears the integrators, the stored order id and the gains, and sets
// the sample scale to its maximum.
`timescale 1ns / 1ps
`default_nettype none
module multi_axis_pi_position_controller_top (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  mpc_in_if.sink                            in_if,
  mpc_out_if.source                         out_if,
  input  wire logic                         cfg_we_i,
  input  wire logic [1:0]                   cfg_index_i,
  input  wire logic [mpc_pkg::CFG_W-1:0]    cfg_data_i
);

  localparam int M  = mpc_pkg::MOTORS;
  localparam int GW = mpc_pkg::GAIN_W;
  localparam int PW = mpc_pkg::POS_W;

  mpc_pkg::state_e       state_q, state_d;
  mpc_pkg::lane_ctrl_t   ctrl;
  logic                  in_acc;
  logic                  load_out;
  logic                  order_chg;

  logic [mpc_pkg::CFG_W-1:0]   kp_q, ki_q;
  logic [GW-1:0]               scale_q;
  logic [mpc_pkg::ORDER_W-1:0] last_order_q;
  logic                        out_valid_q;

  logic signed [PW-1:0] tgt [M];
  logic signed [PW-1:0] pos [M];
  logic signed [PW-1:0] spd [M];
  logic signed [PW-1:0] spd_q [M];

  assign tgt[0] = in_if.target_0;
  assign tgt[1] = in_if.target_1;
  assign tgt[2] = in_if.target_2;
  assign tgt[3] = in_if.target_3;
  assign pos[0] = in_if.position_0;
  assign pos[1] = in_if.position_1;
  assign pos[2] = in_if.position_2;
  assign pos[3] = in_if.position_3;

  assign in_acc    = in_if.valid && in_if.ready;
  assign order_chg = in_if.order_id != last_order_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mpc_pkg::S_IDLE: begin
        if (in_if.valid) state_d = mpc_pkg::S_MUL;
      end
      mpc_pkg::S_MUL: state_d = mpc_pkg::S_INT;
      mpc_pkg::S_INT: state_d = mpc_pkg::S_KI;
      mpc_pkg::S_KI:  state_d = mpc_pkg::S_OUT;
      mpc_pkg::S_OUT: begin
        if (!out_valid_q || out_if.ready) state_d = mpc_pkg::S_IDLE;
      end
      default: state_d = mpc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_if.ready = state_q == mpc_pkg::S_IDLE;
    ctrl.start  = in_acc;
    ctrl.mul    = state_q == mpc_pkg::S_MUL;
    ctrl.integ  = state_q == mpc_pkg::S_INT;
    ctrl.ki     = state_q == mpc_pkg::S_KI;
    load_out    = (state_q == mpc_pkg::S_OUT) && (!out_valid_q || out_if.ready);
  end

  for (genvar g = 0; g < M; g++) begin : g_lane
    mpc_lane u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .clr_i      (order_chg && !in_if.inhibit_mask[g]),
      .target_i   (tgt[g]),
      .position_i (pos[g]),
      .kp_i       (kp_q[g*GW +: GW]),
      .ki_i       (ki_q[g*GW +: GW]),
      .scale_i    (scale_q),
      .speed_o    (spd[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= mpc_pkg::S_IDLE;
      last_order_q <= '0;
      out_valid_q  <= 1'b0;
      kp_q         <= '0;
      ki_q         <= '0;
      scale_q      <= mpc_pkg::SCALE_RESET;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        last_order_q <= in_if.order_id;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          mpc_pkg::CFG_KP:    kp_q    <= cfg_data_i;
          mpc_pkg::CFG_KI:    ki_q    <= cfg_data_i;
          mpc_pkg::CFG_SCALE: scale_q <= cfg_data_i[GW-1:0];
          default: ;
        endcase
      end
    end
  end

  // merge stage
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      spd_q <= spd;
    end
  end

  assign out_if.valid   = out_valid_q;
  assign out_if.speed_0 = spd_q[0];
  assign out_if.speed_1 = spd_q[1];
  assign out_if.speed_2 = spd_q[2];
  assign out_if.speed_3 = spd_q[3];

  a_acc_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == mpc_pkg::S_MUL)
    else $error("accepted item did not start the lanes");

  a_hold_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mpc_pkg::S_OUT) && out_valid_q && !out_if.ready
      |=> state_q == mpc_pkg::S_OUT)
    else $error("result overwrote an untaken item");

  a_one_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({ctrl.start, ctrl.mul, ctrl.integ, ctrl.ki}))
    else $error("lane steps overlap");

  a_order_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> last_order_q == $past(in_if.order_id))
    else $error("order id not stored");

endmodule
`default_nettype wire
